FILE: rtl/dtor_pkg.sv
`timescale 1ns / 1ps

package dtor_pkg;

   // Width of the slot number carried in a result; larger tables report the low bits.
   localparam int SLOT_W = 5;

   // One sighting as it arrives on the request channel.
   typedef struct packed {
      logic [31:0]        device_hash;
      logic [47:0]        source_address;
      logic signed [7:0]  signal_strength;
      logic [31:0]        time_now;
   } req_type;

   // One result as it leaves on the response channel.
   typedef struct packed {
      logic [SLOT_W-1:0]  slot_index;
      logic               was_hit;
      logic               evicted_entry;
      logic [31:0]        sighting_count;
   } rsp_type;

   // One stored table entry. A hash of zero marks the entry as empty.
   typedef struct packed {
      logic [31:0]        device_hash;
      logic [47:0]        source_address;
      logic [31:0]        sighting_count;
      logic [31:0]        last_seen;
      logic signed [7:0]  signal_strength;
   } entry_type;

endpackage

FILE: rtl/dtor_stream_if.sv
`timescale 1ns / 1ps

interface dtor_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/device_table_oldest_replace.sv
`timescale 1ns / 1ps

// Device sighting table with least-recently-seen replacement.
// The request channel (req_stream) carries one sighting per transfer: device hash,
// source address, signal strength and the current time. The response channel
// (rsp_stream) returns one transfer per sighting: the slot that was updated or
// allocated, whether the hash was already present, whether an occupied entry was
// replaced, and the entry's sighting count after the update.
// A sighting is handled by a sequencer that reads the table memory one entry per
// cycle and runs each entry through one shared match/empty/oldest compare stage.
// The scan stops at the first matching entry; a miss scans every entry. The block
// takes one sighting at a time: a new sighting is accepted only after the previous
// one has been written to the table.
// The result sits in an output register. If the receiver stalls, the next
// sighting is still taken and scanned, and its table write waits until the
// previous result has been transferred.
// Reset clears every entry at once through per-entry valid bits; an entry that
// was never written reads as all zero. No clearing pass is needed, and the block
// is ready as soon as reset is released.
module device_table_oldest_replace #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic          clock,
   input  logic          reset,
   dtor_stream_if.sink   req_stream,
   dtor_stream_if.source rsp_stream
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   state_type            state_ff;
   dtor_pkg::req_type    req_ff;
   dtor_pkg::rsp_type    rsp_ff;
   logic                 rsp_valid_ff;

   // Scan sequencer: one read issued per cycle, processed in the next cycle.
   logic [IDX_W-1:0]     scan_idx_ff;
   logic                 issue_ff;
   logic [IDX_W-1:0]     proc_idx_ff;
   logic                 proc_vld_ff;

   // Running search results.
   logic                 have_empty_ff;
   logic [IDX_W-1:0]     empty_idx_ff;
   logic [IDX_W-1:0]     oldest_idx_ff;
   logic [31:0]          oldest_time_ff;

   // Decision carried into the write step.
   logic                 hit_ff;
   logic                 evict_ff;
   logic [IDX_W-1:0]     slot_ff;
   logic [31:0]          count_ff;

   // Table memory and its valid bits.
   dtor_pkg::entry_type  entry_mem [TABLE_ENTRIES];
   dtor_pkg::entry_type  rd_entry_ff;
   logic                 rd_valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;

   dtor_pkg::entry_type  entry_seen;
   dtor_pkg::entry_type  new_entry;
   logic                 is_match;
   logic                 is_empty;
   logic                 is_older;
   logic                 take_oldest;
   logic                 have_empty_now;
   logic [IDX_W-1:0]     empty_idx_now;
   logic [IDX_W-1:0]     oldest_idx_now;
   logic                 req_take;
   logic                 write_go;
   logic [IDX_W+dtor_pkg::SLOT_W-1:0] slot_wide;

   assign req_take = req_stream.valid && req_stream.ready;
   assign req_stream.ready = (state_ff == ST_IDLE);
   assign rsp_stream.valid = rsp_valid_ff;
   assign rsp_stream.payload = rsp_ff;

   // An entry that was never written since reset reads as all zero, i.e. empty.
   assign entry_seen = rd_valid_ff ? rd_entry_ff : '0;

   // The shared compare stage: hash match, empty test and last-seen compare.
   assign is_match = (entry_seen.device_hash == req_ff.device_hash);
   assign is_empty = (entry_seen.device_hash == '0);
   assign is_older = (entry_seen.last_seen < oldest_time_ff);
   // The first entry seeds the oldest search; later ones replace it only when
   // strictly older, which keeps the lowest index on ties.
   assign take_oldest = (proc_idx_ff == '0) || is_older;

   // Search results including the entry being processed this cycle.
   assign have_empty_now = have_empty_ff || is_empty;
   assign empty_idx_now  = have_empty_ff ? empty_idx_ff : proc_idx_ff;
   assign oldest_idx_now = take_oldest ? proc_idx_ff : oldest_idx_ff;

   // The write waits only for the output register to be free.
   assign write_go = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_stream.ready);

   always_comb begin
      new_entry.device_hash     = req_ff.device_hash;
      new_entry.source_address  = req_ff.source_address;
      new_entry.sighting_count  = count_ff;
      new_entry.last_seen       = req_ff.time_now;
      new_entry.signal_strength = req_ff.signal_strength;
   end

   assign slot_wide = {{dtor_pkg::SLOT_W{1'b0}}, slot_ff};

   // Sequencer, search state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         issue_ff      <= 1'b0;
         proc_vld_ff   <= 1'b0;
         have_empty_ff <= 1'b0;
         hit_ff        <= 1'b0;
         evict_ff      <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_stream.ready && !write_go) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  req_ff        <= req_stream.payload;
                  scan_idx_ff   <= '0;
                  issue_ff      <= 1'b1;
                  proc_vld_ff   <= 1'b0;
                  have_empty_ff <= 1'b0;
                  state_ff      <= ST_SCAN;
               end
            end

            ST_SCAN: begin
               proc_idx_ff <= scan_idx_ff;
               if (proc_vld_ff && is_match) begin
                  // Hit: the scan stops at this entry.
                  hit_ff      <= 1'b1;
                  evict_ff    <= 1'b0;
                  slot_ff     <= proc_idx_ff;
                  count_ff    <= entry_seen.sighting_count + 32'd1;
                  issue_ff    <= 1'b0;
                  proc_vld_ff <= 1'b0;
                  state_ff    <= ST_WRITE;
               end else begin
                  // The last read is issued in the cycle before the last entry is
                  // processed, so the processing valid falls on its own.
                  proc_vld_ff <= issue_ff;
                  if (issue_ff) begin
                     scan_idx_ff <= scan_idx_ff + 1'b1;
                     if (scan_idx_ff == LAST_IDX) begin
                        issue_ff <= 1'b0;
                     end
                  end
                  if (proc_vld_ff) begin
                     have_empty_ff <= have_empty_now;
                     empty_idx_ff  <= empty_idx_now;
                     if (take_oldest) begin
                        oldest_idx_ff  <= proc_idx_ff;
                        oldest_time_ff <= entry_seen.last_seen;
                     end
                     if (proc_idx_ff == LAST_IDX) begin
                        // Miss: lowest empty entry, else the oldest one.
                        hit_ff   <= 1'b0;
                        evict_ff <= !have_empty_now;
                        slot_ff  <= have_empty_now ? empty_idx_now : oldest_idx_now;
                        count_ff <= 32'd1;
                        state_ff <= ST_WRITE;
                     end
                  end
               end
            end

            ST_WRITE: begin
               if (write_go) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_ff.slot_index     <= slot_wide[dtor_pkg::SLOT_W-1:0];
                  rsp_ff.was_hit        <= hit_ff;
                  rsp_ff.evicted_entry  <= evict_ff;
                  rsp_ff.sighting_count <= count_ff;
                  state_ff              <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Table memory: one read port driven by the scan counter, one write port.
   always_ff @(posedge clock) begin
      rd_entry_ff <= entry_mem[scan_idx_ff];
      if (write_go) begin
         entry_mem[slot_ff] <= new_entry;
      end
   end

   // Valid bits stand in for clearing the memory at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[scan_idx_ff];
         if (write_go) begin
            valid_ff[slot_ff] <= 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   // A hit never replaces anything.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.was_hit && rsp_ff.evicted_entry))
      else $error("result flags both hit and eviction");

   // An eviction happens only when every entry has been written.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && evict_ff) |-> (&valid_ff))
      else $error("eviction while the table still has unwritten entries");

   // The chosen slot always lies inside the table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (slot_ff <= LAST_IDX))
      else $error("slot outside the table");

   // After a write the slot reads as valid.
   assert property (@(posedge clock) disable iff (reset)
      write_go |=> valid_ff[$past(slot_ff)])
      else $error("written slot not marked valid");

   // Entries are processed only while scanning.
   assert property (@(posedge clock) disable iff (reset)
      proc_vld_ff |-> (state_ff == ST_SCAN))
      else $error("entry processed outside the scan");
`endif

endmodule

FILE: tb/device_table_oldest_replace_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the device sighting table. A scoreboard object keeps its own
// copy of the hash, count and last-seen columns of the table and predicts the response
// to every accepted sighting. Responses are compared field by field, in order, against
// that prediction.
module device_table_oldest_replace_tb;

   localparam int TABLE_ENTRIES = 32;
   // Cycles without any transfer on either channel before the run is declared hung.
   localparam int HANG_LIMIT = 5000;
   localparam int ITEMS_PER_PHASE = 375;
   localparam int POOL_SIZE = 48;
   localparam int HOT_SIZE = 8;

   // The scoreboard predicts the table's behavior one sighting at a time. Only the
   // columns that influence a response are kept: the hash, the count and the
   // last-seen time. Address and strength are written but never read back.
   class sighting_scoreboard;
      bit [31:0] hash_tab [TABLE_ENTRIES];
      bit [31:0] count_tab [TABLE_ENTRIES];
      bit [31:0] seen_tab [TABLE_ENTRIES];
      dtor_pkg::rsp_type slot_updates_due [$];
      int        failures;

      function void note_sighting(dtor_pkg::req_type s);
         dtor_pkg::rsp_type upd;
         int      k;
         int      slot;
         int      oldest;
         int      empty_slot;
         bit      hit;
         bit      found_empty;
         slot = 0;
         oldest = 0;
         empty_slot = 0;
         hit = 1'b0;
         found_empty = 1'b0;
         // Scan lowest index first. The scan stops at the first matching hash, so
         // the empty and oldest searches only see entries below a hit.
         for (k = 0; k < TABLE_ENTRIES; k++) begin
            if (!hit) begin
               if (hash_tab[k] == s.device_hash) begin
                  hit = 1'b1;
                  slot = k;
               end else begin
                  if (hash_tab[k] == 32'd0 && !found_empty) begin
                     found_empty = 1'b1;
                     empty_slot = k;
                  end
                  // Strict less-than keeps the lowest index on equal times.
                  if (seen_tab[k] < seen_tab[oldest]) oldest = k;
               end
            end
         end
         upd.evicted_entry = 1'b0;
         if (!hit) begin
            if (found_empty) begin
               slot = empty_slot;
            end else begin
               slot = oldest;
               upd.evicted_entry = 1'b1;
            end
            count_tab[slot] = 32'd0;
            hash_tab[slot] = s.device_hash;
         end
         count_tab[slot] = count_tab[slot] + 32'd1;
         seen_tab[slot] = s.time_now;
         upd.slot_index = slot[dtor_pkg::SLOT_W-1:0];
         upd.was_hit = hit;
         upd.sighting_count = count_tab[slot];
         slot_updates_due.push_back(upd);
      endfunction

      function void report_failure(string what, dtor_pkg::rsp_type want,
                                   dtor_pkg::rsp_type got);
         failures++;
         if (failures <= 10) begin
            $display("%s: got slot %0d hit %0b evict %0b count %0d",
                     what, got.slot_index, got.was_hit, got.evicted_entry,
                     got.sighting_count);
            $display("   expected slot %0d hit %0b evict %0b count %0d",
                     want.slot_index, want.was_hit, want.evicted_entry,
                     want.sighting_count);
         end
      endfunction

      function void check_result(dtor_pkg::rsp_type got);
         dtor_pkg::rsp_type want;
         if (slot_updates_due.size() == 0) begin
            report_failure("unexpected response", '0, got);
            return;
         end
         want = slot_updates_due.pop_front();
         if (got.slot_index !== want.slot_index || got.was_hit !== want.was_hit ||
             got.evicted_entry !== want.evicted_entry ||
             got.sighting_count !== want.sighting_count) begin
            report_failure("response mismatch", want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   dtor_stream_if #(.payload_type(dtor_pkg::req_type)) req_if ();
   dtor_stream_if #(.payload_type(dtor_pkg::rsp_type)) rsp_if ();

   device_table_oldest_replace #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if)
   );

   sighting_scoreboard sb;

   // Percentages of cycles in which the sender holds off and the receiver stalls.
   // The main sequence changes them from phase to phase.
   int send_idle_pct;
   int recv_stall_pct;
   int idle_cycles;

   // Device hashes that recur. The pool is larger than the table, so once the table
   // is full, sightings of pool members keep forcing the oldest entry out.
   bit [31:0] hash_pool [POOL_SIZE];
   bit [31:0] now_ms;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // The receiver decides afresh at every edge whether it can take a transfer.
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Every response transfer is handed to the scoreboard. All signals are driven with
   // nonblocking assignments, so the values read here are the ones the block saw.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
   end

   // Watchdog: a run in which nothing moves on either channel for too long is hung.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic dtor_pkg::req_type make_sighting(bit [31:0] hash, bit [47:0] addr,
                                                       bit [7:0] strength,
                                                       bit [31:0] stamp);
      dtor_pkg::req_type s;
      s.device_hash = hash;
      s.source_address = addr;
      s.signal_strength = strength;
      s.time_now = stamp;
      return s;
   endfunction

   // Offers one sighting after a random hold-off and returns once it is transferred.
   // The sighting is noted only at the edge that accepts it. Valid stays high when the
   // next call has no hold-off, so it is never lowered and raised in one time step.
   task automatic send_sighting(input dtor_pkg::req_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= s;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_sighting(s);
   endtask

   // Random sightings. Most hashes come from the recurring pool, a hot subset of it
   // gives frequent hits, and a few are zero or entirely fresh. Time mostly creeps
   // forward in small steps, with repeats so that last-seen times tie, and now and
   // then jumps to a random value or to either end of its range.
   task automatic send_random_sightings(input int count);
      int      n;
      int      pick;
      bit [31:0] hash;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 5) hash = 32'd0;
         else if (pick < 10) hash = $urandom;
         else if (pick < 50) hash = hash_pool[$urandom_range(HOT_SIZE - 1)];
         else hash = hash_pool[$urandom_range(POOL_SIZE - 1)];
         pick = $urandom_range(99);
         if (pick < 3) now_ms = $urandom;
         else if (pick < 4) now_ms = 32'd0;
         else if (pick < 5) now_ms = 32'hFFFF_FFFF;
         else now_ms = now_ms + $urandom_range(2);
         send_sighting(make_sighting(hash, {16'($urandom), 32'($urandom)}, 8'($urandom),
                                     now_ms));
      end
   endtask

   initial begin
      int k;
      sb = new;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      now_ms = 32'd100;
      for (k = 0; k < POOL_SIZE; k++) begin
         hash_pool[k] = $urandom;
         if (hash_pool[k] == 32'd0) hash_pool[k] = k + 1;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed sightings. A zero hash on an empty table matches entry 0 as a hit and
      // its count keeps climbing. A new hash then claims that same entry, because a
      // zero hash also marks it empty. Field extremes ride along on the way.
      send_sighting(make_sighting(32'd0, 48'd0, 8'h80, 32'd0));
      send_sighting(make_sighting(32'd0, 48'hFFFF_FFFF_FFFF, 8'h7F, 32'hFFFF_FFFF));
      send_sighting(make_sighting(32'hFFFF_FFFF, 48'd1, 8'h00, 32'd1));
      send_sighting(make_sighting(32'hFFFF_FFFF, 48'h8000_0000_0000, 8'hFF, 32'd2));
      send_sighting(make_sighting(32'h0000_0001, 48'h5555_5555_5555, 8'h01, 32'd3));
      send_sighting(make_sighting(32'h8000_0000, 48'hAAAA_AAAA_AAAA, 8'hC4, 32'd4));
      // The next zero hash hits the first empty entry above the occupied ones, and a
      // fresh hash then takes that entry over with a count of one.
      send_sighting(make_sighting(32'd0, 48'h0123_4567_89AB, 8'hB0, 32'd5));
      send_sighting(make_sighting(32'h5A5A_5A5A, 48'hFEDC_BA98_7654, 8'h40, 32'd6));
      // Moving an entry's last-seen time back to zero makes it the oldest one, which
      // the random part will evict first once the table fills up.
      send_sighting(make_sighting(32'h0000_0001, 48'h0000_FFFF_0000, 8'hE2, 32'd0));
      send_sighting(make_sighting(32'h8000_0000, 48'hFFFF_0000_FFFF, 8'h1E, 32'hFFFF_FFFF));

      // Random phases: free-running, a sparse sender, a stalling receiver, and
      // light pressure on both sides.
      send_random_sightings(ITEMS_PER_PHASE);
      send_idle_pct = 88;
      send_random_sightings(ITEMS_PER_PHASE);
      send_idle_pct = 0;
      recv_stall_pct = 88;
      send_random_sightings(ITEMS_PER_PHASE);
      send_idle_pct = 17;
      recv_stall_pct = 17;
      send_random_sightings(ITEMS_PER_PHASE);
      req_if.valid <= 1'b0;

      // Drain: every predicted response must arrive, then a quiet stretch longer than
      // a full table scan catches any response that should not be there.
      while (sb.slot_updates_due.size() != 0) @(posedge clock);
      repeat (TABLE_ENTRIES + 8) @(posedge clock);

      if (sb.failures == 0 && sb.slot_updates_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/dtor_pkg.sv
rtl/dtor_stream_if.sv
rtl/device_table_oldest_replace.sv
tb/device_table_oldest_replace_tb.sv
